@@ sv/transfer_packet_parse_and_check_top_defines.svh @@
// assertion macros for the transfer packet parser and checker
// used by modules that have clk and arst_n in scope; no other dependencies
`ifndef TRANSFER_PACKET_PARSE_AND_CHECK_TOP_DEFINES_SVH
`define TRANSFER_PACKET_PARSE_AND_CHECK_TOP_DEFINES_SVH

`ifndef ASSERT_OFF

// property holds at every rising clock edge out of reset
`define TPPC_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// same-cycle implication
`define TPPC_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define TPPC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`else

`define TPPC_ASSERT(lbl, prop, msg)
`define TPPC_ASSERT_IMPL(lbl, ante, cons, msg)
`define TPPC_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

@@ sv/tppc_pkg.sv @@
// types and constants for the transfer packet parser and checker
// no dependencies
package tppc_pkg;

	// packet type codes
	localparam logic [15:0] TYPE_START         = 16'd0;
	localparam logic [15:0] TYPE_SHARD         = 16'd1;
	localparam logic [15:0] TYPE_SHARD_END     = 16'd2;
	localparam logic [15:0] TYPE_REQUEST       = 16'd3;
	localparam logic [15:0] TYPE_COMPLETE      = 16'd4;
	localparam logic [15:0] TYPE_FLAGGED_SHARD = 16'd5;

	// header offsets
	localparam logic [15:0] OFF_SUM_HI = 16'd4;
	localparam logic [15:0] OFF_SUM_LO = 16'd5;
	// a packet never ends before this offset
	localparam logic [15:0] OFF_MIN_LAST = 16'd5;

	localparam int RESULT_BITS = 188;
	localparam int TDATA_BITS  = 192;

	typedef enum logic [1:0] {
		VERDICT_OK       = 2'd0,
		VERDICT_UNKNOWN  = 2'd1,
		VERDICT_SIZE     = 2'd2,
		VERDICT_CHECKSUM = 2'd3
	} verdict_t;

	typedef struct packed {
		logic [15:0] payload_length;
		logic [15:0] range_count;
		logic [15:0] single_count;
		logic [31:0] shard_total;
		logic [39:0] file_length;
		logic        success_flag;
		logic        last_shard;
		logic [31:0] shard_number;
		logic [15:0] transfer_id;
		verdict_t    verdict;
		logic [15:0] packet_type;
	} result_t;

endpackage

@@ sv/tppc_parse.sv @@
// per-packet state: offset, checksum, latched header fields, summary result
// depends on tppc_pkg and the assertion macro header
`include "transfer_packet_parse_and_check_top_defines.svh"

module tppc_parse (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step,
	input  logic [7:0]        data,
	output logic              at_last,
	output tppc_pkg::result_t result
);
	import tppc_pkg::*;

	logic [15:0] byte_offset_q;
	logic [15:0] last_offset_q;
	logic [15:0] running_sum_q;
	logic [15:0] received_sum_q;
	logic [15:0] type_word_q;
	logic [15:0] id_word_q;
	logic [31:0] shard_word_q;
	logic [39:0] size_word_q;
	logic [31:0] total_word_q;
	logic [15:0] singles_word_q;
	logic [15:0] ranges_word_q;
	logic        success_bit_q;

	logic [15:0] last_offset_d;
	logic [15:0] running_sum_d;
	logic [15:0] received_sum_d;
	logic [15:0] type_word_d;
	logic [15:0] id_word_d;
	logic [31:0] shard_word_d;
	logic [39:0] size_word_d;
	logic [31:0] total_word_d;
	logic [15:0] singles_word_d;
	logic [15:0] ranges_word_d;
	logic        success_bit_d;

	logic [15:0] off;
	logic        is_start;
	logic        is_shard;
	logic        is_small;
	logic [16:0] size;
	logic        known;
	logic        size_ok;

	assign off     = byte_offset_q;
	assign at_last = (off >= OFF_MIN_LAST) && (off >= last_offset_q);

	assign is_start = (type_word_q == TYPE_START);
	assign is_shard = (type_word_q == TYPE_SHARD) || (type_word_q == TYPE_FLAGGED_SHARD);
	assign is_small = (type_word_q >= TYPE_SHARD_END) && (type_word_q <= TYPE_COMPLETE);

	// field latching for the current word
	always_comb begin
		last_offset_d  = last_offset_q;
		running_sum_d  = running_sum_q;
		received_sum_d = received_sum_q;
		type_word_d    = type_word_q;
		id_word_d      = id_word_q;
		shard_word_d   = shard_word_q;
		size_word_d    = size_word_q;
		total_word_d   = total_word_q;
		singles_word_d = singles_word_q;
		ranges_word_d  = ranges_word_q;
		success_bit_d  = success_bit_q;

		// checksum covers every byte but the checksum itself
		if (off != OFF_SUM_HI && off != OFF_SUM_LO) begin
			running_sum_d = running_sum_q + {8'd0, data};
		end

		if (off <= 16'd1) begin
			type_word_d = {type_word_q[7:0], data};
		end else if (off <= 16'd3) begin
			last_offset_d = {last_offset_q[7:0], data};
		end else if (off <= OFF_SUM_LO) begin
			received_sum_d = {received_sum_q[7:0], data};
		end else if (is_start) begin
			if (off >= 16'd22 && off <= 16'd26) begin
				size_word_d = {size_word_q[31:0], data};
			end else if (off >= 16'd27 && off <= 16'd30) begin
				total_word_d = {total_word_q[23:0], data};
			end else if (off == 16'd31 || off == 16'd32) begin
				id_word_d = {id_word_q[7:0], data};
			end
		end else if (is_shard) begin
			if (off <= 16'd9) begin
				shard_word_d = {shard_word_q[23:0], data};
			end else if (off <= 16'd11) begin
				id_word_d = {id_word_q[7:0], data};
			end
		end else if (is_small) begin
			if (off <= 16'd7) begin
				id_word_d = {id_word_q[7:0], data};
			end else if (type_word_q == TYPE_REQUEST && off <= 16'd9) begin
				singles_word_d = {singles_word_q[7:0], data};
			end else if (type_word_q == TYPE_REQUEST && off <= 16'd11) begin
				ranges_word_d = {ranges_word_q[7:0], data};
			end else if (type_word_q == TYPE_COMPLETE && off == 16'd8) begin
				success_bit_d = data[7];
			end
		end
	end

	// size rule of the type
	assign size  = {1'b0, last_offset_q} + 17'd1;
	assign known = (type_word_q <= TYPE_FLAGGED_SHARD);

	always_comb begin
		case (type_word_q)
			TYPE_START:         size_ok = (size >= 17'd32);
			TYPE_SHARD:         size_ok = (size >= 17'd12);
			TYPE_SHARD_END:     size_ok = (size == 17'd8);
			TYPE_REQUEST:       size_ok = (size >= 17'd10);
			TYPE_COMPLETE:      size_ok = (size == 17'd9);
			TYPE_FLAGGED_SHARD: size_ok = (size >= 17'd12);
			default:            size_ok = 1'b0;
		endcase
		if (last_offset_q < OFF_MIN_LAST) begin
			size_ok = 1'b0;
		end
	end

	// summary built from the updated fields
	always_comb begin
		result = '0;
		result.packet_type = type_word_q;
		if (!known) begin
			result.verdict = VERDICT_UNKNOWN;
		end else if (!size_ok) begin
			result.verdict = VERDICT_SIZE;
		end else if (running_sum_d != received_sum_d) begin
			result.verdict = VERDICT_CHECKSUM;
		end else begin
			result.verdict = VERDICT_OK;
		end
		if (known) begin
			result.transfer_id = id_word_d;
		end
		case (type_word_q)
			TYPE_START: begin
				result.file_length    = size_word_d;
				result.shard_total    = total_word_d;
				result.payload_length = (size >= 17'd33) ? 16'(size - 17'd33) : 16'd0;
			end
			TYPE_SHARD: begin
				result.shard_number   = shard_word_d;
				result.payload_length = (size >= 17'd12) ? 16'(size - 17'd12) : 16'd0;
			end
			TYPE_FLAGGED_SHARD: begin
				result.shard_number   = {1'b0, shard_word_d[30:0]};
				result.last_shard     = shard_word_d[31];
				result.payload_length = (size >= 17'd12) ? 16'(size - 17'd12) : 16'd0;
			end
			TYPE_REQUEST: begin
				result.single_count = singles_word_d;
				result.range_count  = ranges_word_d;
			end
			TYPE_COMPLETE: begin
				result.success_flag = success_bit_d;
			end
			default: begin
			end
		endcase
	end

	// state registers, cleared after the last word of a packet
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_offset_q  <= '0;
			last_offset_q  <= '0;
			running_sum_q  <= '0;
			received_sum_q <= '0;
			type_word_q    <= '0;
			id_word_q      <= '0;
			shard_word_q   <= '0;
			size_word_q    <= '0;
			total_word_q   <= '0;
			singles_word_q <= '0;
			ranges_word_q  <= '0;
			success_bit_q  <= 1'b0;
		end else if (step) begin
			if (at_last) begin
				byte_offset_q  <= '0;
				last_offset_q  <= '0;
				running_sum_q  <= '0;
				received_sum_q <= '0;
				type_word_q    <= '0;
				id_word_q      <= '0;
				shard_word_q   <= '0;
				size_word_q    <= '0;
				total_word_q   <= '0;
				singles_word_q <= '0;
				ranges_word_q  <= '0;
				success_bit_q  <= 1'b0;
			end else begin
				byte_offset_q  <= off + 16'd1;
				last_offset_q  <= last_offset_d;
				running_sum_q  <= running_sum_d;
				received_sum_q <= received_sum_d;
				type_word_q    <= type_word_d;
				id_word_q      <= id_word_d;
				shard_word_q   <= shard_word_d;
				size_word_q    <= size_word_d;
				total_word_q   <= total_word_d;
				singles_word_q <= singles_word_d;
				ranges_word_q  <= ranges_word_d;
				success_bit_q  <= success_bit_d;
			end
		end
	end

	`TPPC_ASSERT_NEXT(a_clear_after_last, step && at_last, byte_offset_q == 16'd0 && running_sum_q == 16'd0, "state not cleared after packet end")
	`TPPC_ASSERT_NEXT(a_offset_advance, step && !at_last, byte_offset_q == 16'($past(byte_offset_q) + 16'd1), "byte offset did not advance")
	`TPPC_ASSERT_IMPL(a_unknown_type, step && at_last, (result.verdict == VERDICT_UNKNOWN) == (type_word_q > TYPE_FLAGGED_SHARD), "unknown-type verdict disagrees with type")
	`TPPC_ASSERT_IMPL(a_ok_needs_length, step && at_last && result.verdict == VERDICT_OK, last_offset_q >= OFF_MIN_LAST && running_sum_d == received_sum_d, "ok verdict on short or bad packet")

endmodule

@@ sv/transfer_packet_parse_and_check_top.sv @@
// channel   dir  signals                          word
// s_axis    in   tvalid tready tdata[7:0]         one packet byte
// m_axis    out  tvalid tready tdata[191:0]       one packet summary
//
// one byte is taken per cycle unless a byte that ends a packet is held in the input register
// bytes go through an input register, then the parse state into the result register
// a byte that ends a packet waits in the input register only while the result register is full
// and not being drained; other bytes never stall
// arst_n clears the offset, checksum and all latched fields; no clearing pass is needed
//
// top level of the transfer packet parser and checker; depends on tppc_pkg and tppc_parse
module transfer_packet_parse_and_check_top (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	input  logic [7:0]   s_axis_tdata,  // [7:0] packet_byte
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// [15:0] packet_type, [17:16] verdict, [33:18] transfer_id, [65:34] shard_number,
	// [66] last_shard, [67] success_flag, [107:68] file_length, [139:108] shard_total,
	// [155:140] single_count, [171:156] range_count, [187:172] payload_length, rest zero
	output logic [191:0] m_axis_tdata
);
	import tppc_pkg::*;

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       at_last;
	logic       out_free;
	logic       step;
	result_t    result;
	result_t    result_q;
	logic       out_valid_q;

	// byte in the input register goes through unless it needs a busy result slot
	assign out_free      = !out_valid_q || m_axis_tready;
	assign step          = valid_s1 && (!at_last || out_free);
	assign s_axis_tready = !valid_s1 || step;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tvalid && s_axis_tready) begin
			valid_s1 <= 1'b1;
		end else if (step) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			byte_s1 <= s_axis_tdata;
		end
	end

	tppc_parse u_parse (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (step),
		.data    (byte_s1),
		.at_last (at_last),
		.result  (result)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (step && at_last) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step && at_last) begin
			result_q <= result;
		end
	end

	// pack fields from the lowest bit up
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {
		4'd0,
		result_q.payload_length,
		result_q.range_count,
		result_q.single_count,
		result_q.shard_total,
		result_q.file_length,
		result_q.success_flag,
		result_q.last_shard,
		result_q.shard_number,
		result_q.transfer_id,
		result_q.verdict,
		result_q.packet_type
	};

endmodule

@@ sim/tb_transfer_packet_parse_and_check_top.sv @@
// self-checking bench for the transfer packet parser and checker: streams packet bytes,
// predicts each packet summary, and compares every summary word field by field
// depends on tppc_pkg and transfer_packet_parse_and_check_top
module tb_transfer_packet_parse_and_check_top;
	timeunit 1ns;
	timeprecision 1ps;

	import tppc_pkg::*;

	localparam int FILL_RANDOM = 0;
	localparam int FILL_ZERO   = 1;
	localparam int FILL_ONES   = 2;
	localparam int PHASE_BYTES = 330;
	localparam int STALL_LIMIT = 4000;
	localparam int MAX_REPORTS = 40;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         s_axis_tvalid = 1'b0;
	logic         s_axis_tready;
	logic [7:0]   s_axis_tdata = 8'h00;   // [7:0] packet_byte
	logic         m_axis_tvalid;
	logic         m_axis_tready = 1'b0;
	logic [191:0] m_axis_tdata;           // result_t in [187:0], rest zero

	// bytes waiting to be sent and summaries waiting to arrive
	logic [7:0] byte_q[$];
	result_t    summary_q[$];

	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	bit byte_taken = 1'b0;
	int err_count = 0;
	int stall_cycles = 0;
	int bytes_queued = 0;
	int packets_queued = 0;
	int verdict_seen[4] = '{0, 0, 0, 0};

	// parser state as predicted
	logic [15:0] pk_offset = '0;
	logic [15:0] pk_last = '0;
	logic [15:0] pk_sum = '0;
	logic [15:0] pk_rx_sum = '0;
	logic [15:0] pk_type = '0;
	logic [15:0] pk_id = '0;
	logic [31:0] pk_shard = '0;
	logic [39:0] pk_size = '0;
	logic [31:0] pk_total = '0;
	logic [15:0] pk_singles = '0;
	logic [15:0] pk_ranges = '0;
	logic        pk_success = 1'b0;

	transfer_packet_parse_and_check_top u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	// 12 ns clock
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// advance the parse by one accepted byte, queue the summary on the last one
	task automatic parse_byte(input logic [7:0] b);
		result_t     r;
		logic [16:0] size;
		logic        known;
		logic        size_ok;
		if (pk_offset != OFF_SUM_HI && pk_offset != OFF_SUM_LO)
			pk_sum = pk_sum + 16'(b);
		if (pk_offset <= 16'd1) begin
			pk_type = {pk_type[7:0], b};
		end else if (pk_offset <= 16'd3) begin
			pk_last = {pk_last[7:0], b};
		end else if (pk_offset <= OFF_SUM_LO) begin
			pk_rx_sum = {pk_rx_sum[7:0], b};
		end else if (pk_type == TYPE_START) begin
			// file size, shard total, then transfer id
			if (pk_offset >= 16'd22 && pk_offset <= 16'd26)
				pk_size = {pk_size[31:0], b};
			else if (pk_offset >= 16'd27 && pk_offset <= 16'd30)
				pk_total = {pk_total[23:0], b};
			else if (pk_offset == 16'd31 || pk_offset == 16'd32)
				pk_id = {pk_id[7:0], b};
		end else if (pk_type == TYPE_SHARD || pk_type == TYPE_FLAGGED_SHARD) begin
			if (pk_offset <= 16'd9)
				pk_shard = {pk_shard[23:0], b};
			else if (pk_offset <= 16'd11)
				pk_id = {pk_id[7:0], b};
		end else if (pk_type >= TYPE_SHARD_END && pk_type <= TYPE_COMPLETE) begin
			if (pk_offset <= 16'd7)
				pk_id = {pk_id[7:0], b};
			else if (pk_type == TYPE_REQUEST && pk_offset <= 16'd9)
				pk_singles = {pk_singles[7:0], b};
			else if (pk_type == TYPE_REQUEST && pk_offset <= 16'd11)
				pk_ranges = {pk_ranges[7:0], b};
			else if (pk_type == TYPE_COMPLETE && pk_offset == 16'd8)
				pk_success = b[7];
		end

		if (pk_offset < OFF_MIN_LAST || pk_offset < pk_last) begin
			pk_offset = pk_offset + 16'd1;
			return;
		end

		// last byte: size rule of the type, then verdict in priority order
		size = 17'(pk_last) + 17'd1;
		known = pk_type <= TYPE_FLAGGED_SHARD;
		case (pk_type)
			TYPE_START:         size_ok = size >= 17'd32;
			TYPE_SHARD:         size_ok = size >= 17'd12;
			TYPE_SHARD_END:     size_ok = size == 17'd8;
			TYPE_REQUEST:       size_ok = size >= 17'd10;
			TYPE_COMPLETE:      size_ok = size == 17'd9;
			TYPE_FLAGGED_SHARD: size_ok = size >= 17'd12;
			default:            size_ok = 1'b0;
		endcase
		if (pk_last < OFF_MIN_LAST)
			size_ok = 1'b0;

		r = '0;
		r.packet_type = pk_type;
		if (!known)
			r.verdict = VERDICT_UNKNOWN;
		else if (!size_ok)
			r.verdict = VERDICT_SIZE;
		else if (pk_sum != pk_rx_sum)
			r.verdict = VERDICT_CHECKSUM;
		else
			r.verdict = VERDICT_OK;
		if (known)
			r.transfer_id = pk_id;
		case (pk_type)
			TYPE_START: begin
				r.file_length = pk_size;
				r.shard_total = pk_total;
				r.payload_length = size >= 17'd33 ? 16'(size - 17'd33) : 16'd0;
			end
			TYPE_SHARD: begin
				r.shard_number = pk_shard;
				r.payload_length = size >= 17'd12 ? 16'(size - 17'd12) : 16'd0;
			end
			TYPE_FLAGGED_SHARD: begin
				r.shard_number = {1'b0, pk_shard[30:0]};
				r.last_shard = pk_shard[31];
				r.payload_length = size >= 17'd12 ? 16'(size - 17'd12) : 16'd0;
			end
			TYPE_REQUEST: begin
				r.single_count = pk_singles;
				r.range_count = pk_ranges;
			end
			TYPE_COMPLETE: begin
				r.success_flag = pk_success;
			end
			default: ;
		endcase
		summary_q.push_back(r);

		pk_offset = '0;
		pk_last = '0;
		pk_sum = '0;
		pk_rx_sum = '0;
		pk_type = '0;
		pk_id = '0;
		pk_shard = '0;
		pk_size = '0;
		pk_total = '0;
		pk_singles = '0;
		pk_ranges = '0;
		pk_success = 1'b0;
	endtask

	function automatic void match_field(input string name, input logic [39:0] want,
			input logic [39:0] got);
		if (got !== want) begin
			err_count++;
			if (err_count <= MAX_REPORTS)
				$display("%0t ns: %s expected %0h actual %0h", $time, name, want, got);
		end
	endfunction

	// sender: at each falling edge with no byte pending, next byte or an idle cycle
	always @(negedge clk) begin
		if (arst_n) begin
			if (!s_axis_tvalid || byte_taken) begin
				if (byte_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
					s_axis_tdata <= byte_q.pop_front();
					s_axis_tvalid <= 1'b1;
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	// receiver: random stalls on the summary side
	always @(negedge clk) begin
		if (arst_n)
			m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
	end

	// check each summary word, then feed the accepted byte to the predictor
	always @(posedge clk) begin
		result_t want;
		result_t got;
		byte_taken = s_axis_tvalid && s_axis_tready;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got = result_t'(m_axis_tdata[RESULT_BITS-1:0]);
			if (summary_q.size() == 0) begin
				err_count++;
				if (err_count <= MAX_REPORTS)
					$display("%0t ns: summary with none expected, expected none actual %0h",
						$time, m_axis_tdata);
			end else begin
				want = summary_q.pop_front();
				verdict_seen[want.verdict]++;
				match_field("packet_type", 40'(want.packet_type), 40'(got.packet_type));
				match_field("verdict", 40'(want.verdict), 40'(got.verdict));
				match_field("transfer_id", 40'(want.transfer_id), 40'(got.transfer_id));
				match_field("shard_number", 40'(want.shard_number), 40'(got.shard_number));
				match_field("last_shard", 40'(want.last_shard), 40'(got.last_shard));
				match_field("success_flag", 40'(want.success_flag), 40'(got.success_flag));
				match_field("file_length", want.file_length, got.file_length);
				match_field("shard_total", 40'(want.shard_total), 40'(got.shard_total));
				match_field("single_count", 40'(want.single_count), 40'(got.single_count));
				match_field("range_count", 40'(want.range_count), 40'(got.range_count));
				match_field("payload_length", 40'(want.payload_length),
					40'(got.payload_length));
				match_field("padding", 40'd0, 40'(m_axis_tdata[TDATA_BITS-1:RESULT_BITS]));
			end
		end
		if (arst_n && byte_taken)
			parse_byte(s_axis_tdata);
	end

	// watchdog on cycles with no word moving on either side
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
				stall_cycles = 0;
			else
				stall_cycles++;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("%0t ns: no progress for %0d cycles", $time, stall_cycles);
				$display("tb_transfer_packet_parse_and_check_top: errors");
				$finish;
			end
		end
	end

	// build one packet with a correct or a corrupted checksum
	task automatic queue_packet(input logic [15:0] kind, input logic [15:0] last,
			input int fill, input bit bad_sum);
		logic [7:0]  pkt[$];
		logic [15:0] sum;
		logic [7:0]  v;
		int          n;
		n = (last < OFF_MIN_LAST) ? 6 : int'(last) + 1;
		sum = '0;
		for (int i = 0; i < n; i++) begin
			case (i)
				0: v = kind[15:8];
				1: v = kind[7:0];
				2: v = last[15:8];
				3: v = last[7:0];
				4, 5: v = 8'h00;
				default: begin
					if (fill == FILL_ZERO)
						v = 8'h00;
					else if (fill == FILL_ONES)
						v = 8'hFF;
					else
						v = 8'($urandom_range(0, 255));
				end
			endcase
			pkt.push_back(v);
			if (i != 4 && i != 5)
				sum = sum + 16'(v);
		end
		if (bad_sum)
			sum = sum ^ 16'($urandom_range(1, 65535));
		pkt[4] = sum[15:8];
		pkt[5] = sum[7:0];
		foreach (pkt[i])
			byte_q.push_back(pkt[i]);
		bytes_queued += n;
		packets_queued++;
	endtask

	// mostly well-formed packets of known types, some unknown, short or broken
	task automatic queue_random_packet();
		logic [15:0] kind;
		logic [15:0] last;
		int          pick;
		pick = $urandom_range(0, 99);
		if (pick < 84)
			kind = 16'($urandom_range(0, 5));
		else if (pick < 88)
			kind = 16'hFFFF;
		else
			kind = 16'($urandom_range(6, 65535));
		pick = $urandom_range(0, 99);
		if (pick < 8) begin
			last = 16'($urandom_range(0, 4));
		end else if (pick < 20) begin
			last = 16'($urandom_range(5, 40));
		end else if (pick < 21) begin
			last = 16'($urandom_range(256, 300));
		end else begin
			case (kind)
				TYPE_START:         last = 16'(31 + $urandom_range(0, 8));
				TYPE_SHARD,
				TYPE_FLAGGED_SHARD: last = 16'(11 + $urandom_range(0, 8));
				TYPE_SHARD_END:     last = 16'd7;
				TYPE_REQUEST:       last = 16'(9 + $urandom_range(0, 6));
				TYPE_COMPLETE:      last = 16'd8;
				default:            last = 16'($urandom_range(5, 20));
			endcase
		end
		queue_packet(kind, last, FILL_RANDOM, $urandom_range(0, 9) == 0);
	endtask

	task automatic drain();
		while (byte_q.size() != 0 || s_axis_tvalid)
			@(posedge clk);
		wait (summary_q.size() == 0);
	endtask

	task automatic run_phase(input int send_pct, input int recv_pct);
		int start_bytes;
		send_idle_pct = send_pct;
		recv_idle_pct = recv_pct;
		start_bytes = bytes_queued;
		while (bytes_queued - start_bytes < PHASE_BYTES)
			queue_random_packet();
		drain();
	endtask

	initial begin
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: every type at its size bounds, extreme field values
		send_idle_pct = 18;
		recv_idle_pct = 52;
		queue_packet(TYPE_START, 16'd31, FILL_ONES, 1'b0);
		queue_packet(TYPE_START, 16'd33, FILL_ZERO, 1'b0);
		queue_packet(TYPE_SHARD, 16'd11, FILL_ONES, 1'b0);
		queue_packet(TYPE_FLAGGED_SHARD, 16'd11, FILL_ONES, 1'b0);
		queue_packet(TYPE_FLAGGED_SHARD, 16'd14, FILL_ZERO, 1'b0);
		queue_packet(TYPE_SHARD_END, 16'd7, FILL_ONES, 1'b0);
		queue_packet(TYPE_REQUEST, 16'd9, FILL_ONES, 1'b0);
		queue_packet(TYPE_REQUEST, 16'd11, FILL_RANDOM, 1'b0);
		queue_packet(TYPE_COMPLETE, 16'd8, FILL_ONES, 1'b0);
		queue_packet(TYPE_COMPLETE, 16'd8, FILL_ZERO, 1'b0);
		// unknown types, the largest type word too
		queue_packet(16'd6, 16'd9, FILL_RANDOM, 1'b0);
		queue_packet(16'hFFFF, 16'd7, FILL_ONES, 1'b0);
		// last offset below the header end: packet cut at the checksum
		queue_packet(TYPE_SHARD, 16'd0, FILL_RANDOM, 1'b0);
		queue_packet(16'h0106, 16'd4, FILL_RANDOM, 1'b0);
		// checksum mismatch, wrong fixed sizes, start and shard fields cut short
		queue_packet(TYPE_SHARD_END, 16'd7, FILL_RANDOM, 1'b1);
		queue_packet(TYPE_COMPLETE, 16'd9, FILL_RANDOM, 1'b0);
		queue_packet(TYPE_SHARD_END, 16'd8, FILL_RANDOM, 1'b1);
		queue_packet(TYPE_START, 16'd24, FILL_ONES, 1'b0);
		queue_packet(TYPE_SHARD, 16'd10, FILL_RANDOM, 1'b0);
		drain();

		run_phase(18, 52);
		run_phase(52, 18);
		run_phase(0, 0);
		repeat (8) @(posedge clk);

		$display("%0d packets in %0d bytes under three stall patterns", packets_queued,
			bytes_queued);
		$display("verdicts: %0d ok, %0d unknown type, %0d size, %0d checksum",
			verdict_seen[VERDICT_OK], verdict_seen[VERDICT_UNKNOWN],
			verdict_seen[VERDICT_SIZE], verdict_seen[VERDICT_CHECKSUM]);
		if (err_count == 0 && summary_q.size() == 0) begin
			$display("tb_transfer_packet_parse_and_check_top: clean");
		end else begin
			$display("tb_transfer_packet_parse_and_check_top: errors");
		end
		$finish;
	end

endmodule

@@ transfer_packet_parse_and_check_top.f @@
+incdir+sv
sv/tppc_pkg.sv
sv/tppc_parse.sv
sv/transfer_packet_parse_and_check_top.sv
sim/tb_transfer_packet_parse_and_check_top.sv
